/* sv/bvsc_pkg.sv */
`timescale 1ns / 1ps
// Package for the bit vector set/clear/find unit: item structs, request codes
// and register map constants. No dependencies.
package bvsc_pkg;

   localparam int LEN_W      = 13;
   localparam int IDX_W      = 12;
   localparam int OP_W       = 3;
   localparam int CSR_ADDR_W = 3;

   // Request codes
   localparam logic [OP_W-1:0] OP_READ  = 3'd0;
   localparam logic [OP_W-1:0] OP_SET   = 3'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 3'd2;
   localparam logic [OP_W-1:0] OP_FILL  = 3'd3;
   localparam logic [OP_W-1:0] OP_ZERO  = 3'd4;
   localparam logic [OP_W-1:0] OP_FIND  = 3'd5;

   // Register select (paddr bit 2): the length register sits at byte address 0
   localparam logic CSR_SEL_LEN = 1'b0;
   localparam logic [LEN_W-1:0] LEN_RESET = 13'd4096;

   typedef struct packed {
      logic [OP_W-1:0]  req_type;
      logic [IDX_W-1:0] bit_index;
      logic [LEN_W-1:0] range_end;
      logic             fill_value;
   } bvsc_req_type;

   typedef struct packed {
      logic             flag;
      logic [IDX_W-1:0] found_index;
      logic             range_error;
   } bvsc_rsp_type;

endpackage

/* sv/bit_vector_set_clear_find_unit.sv */
`timescale 1ns / 1ps
// Bit vector set/clear/find unit: word store, sequencer and scan unit.
// Depends on bvsc_pkg.
//
// Usage:
//   Request channel: drive req_data and raise start; the item is taken at the
//   clock edge where start is high and busy is low. busy stays high while the
//   item is worked on. Exactly one result per item appears on rsp_data for a
//   single cycle, marked by rsp_strobe; the receiver cannot stall it.
//   Register port (APB style, pready always high): the length register at
//   byte 0. Write it only while the unit is idle.
// Flow per item (the next item can be taken in the strobe cycle):
//   range errors, empty find range, unused codes: answered without leaving
//   idle (busy never rises).
//   read / set / clear: divide split, one store read, optional write back.
//   fill: every store word covered by the length is written. zero test: the
//     words covered by the length are scanned up to the first set bit.
//   find: the words of the range are scanned up to the first hit; the scan
//     reads one word per cycle.
// Reset: sweep the store to zero, one word per cycle with busy high;
//   register writes are taken as usual meanwhile.
module bit_vector_set_clear_find_unit #(
   parameter int CAPACITY_BITS = 4096,
   parameter int WORD_BITS     = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  bvsc_pkg::bvsc_req_type             req_data,
   output logic                               rsp_strobe,
   output bvsc_pkg::bvsc_rsp_type             rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [bvsc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import bvsc_pkg::*;

   localparam int NUM_WORDS = (CAPACITY_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int CNT_W     = AW + 1;
   localparam int BW        = $clog2(WORD_BITS);
   localparam int BASE_W    = LEN_W + 1;
   // index / WORD_BITS by reciprocal multiply, exact for every LEN_W-bit index
   localparam int DIV_SHIFT = LEN_W + 7;
   localparam int RECIP     = (2 ** DIV_SHIFT + WORD_BITS - 1) / WORD_BITS;
   localparam int RECIP_W   = DIV_SHIFT - 2;
   localparam int PROD_W    = LEN_W + RECIP_W;
   localparam int Q_W       = PROD_W - DIV_SHIFT;

   localparam int ST_W = 3;
   localparam logic [ST_W-1:0] ST_CLEAR  = 3'd0;
   localparam logic [ST_W-1:0] ST_IDLE   = 3'd1;
   localparam logic [ST_W-1:0] ST_MUL    = 3'd2;
   localparam logic [ST_W-1:0] ST_SPLIT  = 3'd3;
   localparam logic [ST_W-1:0] ST_BIT_RD = 3'd4;
   localparam logic [ST_W-1:0] ST_BIT_OP = 3'd5;
   localparam logic [ST_W-1:0] ST_SCAN   = 3'd6;

   // sequencer and control
   logic [ST_W-1:0]   state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  used_len;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [LEN_W-1:0]  num_ff, num_in;
   logic [LEN_W-1:0]  start_ff, start_in;
   logic [LEN_W-1:0]  limit_ff, limit_in;
   logic              fill_ff, fill_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [CNT_W-1:0]  iss_word_ff, iss_word_in;
   logic [BASE_W-1:0] iss_base_ff, iss_base_in;
   logic [BW-1:0]     pos_ff, pos_in;
   logic              exm_valid_ff, exm_valid_in;
   logic [BASE_W-1:0] exm_base_ff, exm_base_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   bvsc_rsp_type      rsp_ff, rsp_in;

   // word store
   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [WORD_BITS-1:0] mem_q_ff;
   logic                 mem_we;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [AW-1:0]        mem_addr;

   // datapath
   logic              accept;
   logic              issue_ok;
   logic [LEN_W-1:0]  idx_ext;
   logic [Q_W-1:0]    quot;
   logic [BASE_W-1:0] split_base;
   logic [BASE_W-1:0] lo_gap, hi_gap;
   logic [BW-1:0]     lo_off;
   logic [BW:0]       hi_off;
   logic [WORD_BITS-1:0] scan_mask, scan_bits, scan_lsb;
   logic              scan_any;
   logic [BW-1:0]     scan_pos;
   logic              csr_write;

   // ---------------------------------------------------------------
   // Register port
   // ---------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign len_in    = (csr_write && (paddr[CSR_ADDR_W-1] == CSR_SEL_LEN)) ?
                      pwdata[LEN_W-1:0] : len_ff;
   assign prdata    = (paddr[CSR_ADDR_W-1] == CSR_SEL_LEN) ? 32'(len_ff) : '0;

   // a length beyond the capacity acts as the capacity
   assign used_len = (32'(len_ff) > CAPACITY_BITS) ? LEN_W'(CAPACITY_BITS) : len_ff;

   // ---------------------------------------------------------------
   // Handshake
   // ---------------------------------------------------------------
   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;
   assign idx_ext    = LEN_W'(req_data.bit_index);

   // ---------------------------------------------------------------
   // Divide split: quotient is the word, remainder the bit position
   // ---------------------------------------------------------------
   assign prod_in    = PROD_W'(num_ff) * PROD_W'(RECIP);
   assign quot       = prod_ff[PROD_W-1:DIV_SHIFT];
   assign split_base = BASE_W'(quot) * BASE_W'(WORD_BITS);

   // ---------------------------------------------------------------
   // Scan unit: mask one store word to [start, limit) and pick its
   // lowest set bit
   // ---------------------------------------------------------------
   assign issue_ok = (iss_base_ff < BASE_W'(limit_ff));
   assign lo_gap   = BASE_W'(start_ff) - exm_base_ff;
   assign hi_gap   = BASE_W'(limit_ff) - exm_base_ff;
   assign lo_off   = (BASE_W'(start_ff) > exm_base_ff) ? BW'(lo_gap) : '0;
   assign hi_off   = (hi_gap >= BASE_W'(WORD_BITS)) ? (BW+1)'(WORD_BITS) : (BW+1)'(hi_gap);

   always_comb begin
      for (int j = 0; j < WORD_BITS; j++) begin
         scan_mask[j] = ((BW+1)'(j) >= {1'b0, lo_off}) && ((BW+1)'(j) < hi_off);
      end
   end

   assign scan_bits = mem_q_ff & scan_mask;
   assign scan_any  = |scan_bits;
   assign scan_lsb  = scan_bits & (~scan_bits + WORD_BITS'(1));

   always_comb begin
      scan_pos = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         if (scan_lsb[j]) begin
            scan_pos = scan_pos | BW'(j);
         end
      end
   end

   // ---------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------
   assign mem_addr = iss_word_ff[AW-1:0];

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      num_in        = num_ff;
      start_in      = start_ff;
      limit_in      = limit_ff;
      fill_in       = fill_ff;
      iss_word_in   = iss_word_ff;
      iss_base_in   = iss_base_ff;
      pos_in        = pos_ff;
      exm_valid_in  = 1'b0;
      exm_base_in   = iss_base_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      mem_we        = 1'b0;
      mem_wdata     = '0;

      case (state_ff)
         ST_CLEAR: begin
            // sweep the store to zero after reset
            mem_we = 1'b1;
            if (iss_word_ff == CNT_W'(NUM_WORDS - 1)) begin
               iss_word_in = '0;
               state_in    = ST_IDLE;
            end else begin
               iss_word_in = iss_word_ff + CNT_W'(1);
            end
         end

         ST_IDLE: begin
            if (accept) begin
               op_in       = req_data.req_type;
               num_in      = idx_ext;
               start_in    = idx_ext;
               limit_in    = req_data.range_end;
               fill_in     = req_data.fill_value;
               iss_word_in = '0;
               iss_base_in = '0;
               case (req_data.req_type)
                  OP_READ, OP_SET, OP_CLEAR: begin
                     if (idx_ext >= used_len) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_in.range_error = 1'b1;
                     end else begin
                        state_in = ST_MUL;
                     end
                  end
                  OP_FILL: begin
                     limit_in = used_len;
                     state_in = ST_SCAN;
                  end
                  OP_ZERO: begin
                     start_in = '0;
                     limit_in = used_len;
                     state_in = ST_SCAN;
                  end
                  OP_FIND: begin
                     if ((req_data.range_end > used_len) || (idx_ext > req_data.range_end)) begin
                        rsp_strobe_in      = 1'b1;
                        rsp_in.range_error = 1'b1;
                     end else if (idx_ext == req_data.range_end) begin
                        // empty range: not found
                        rsp_strobe_in = 1'b1;
                     end else begin
                        state_in = ST_MUL;
                     end
                  end
                  default: begin
                     // unused code: all-zero result
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end

         ST_MUL: begin
            state_in = ST_SPLIT;
         end

         ST_SPLIT: begin
            iss_word_in = CNT_W'(quot);
            iss_base_in = split_base;
            pos_in      = BW'(BASE_W'(num_ff) - split_base);
            state_in    = (op_ff == OP_FIND) ? ST_SCAN : ST_BIT_RD;
         end

         ST_BIT_RD: begin
            state_in = ST_BIT_OP;
         end

         ST_BIT_OP: begin
            rsp_strobe_in = 1'b1;
            rsp_in.flag   = mem_q_ff[pos_ff];
            // write back the changed word for set and clear
            if (op_ff inside {OP_SET, OP_CLEAR}) begin
               mem_we            = 1'b1;
               mem_wdata         = mem_q_ff;
               mem_wdata[pos_ff] = (op_ff == OP_SET);
            end
            state_in = ST_IDLE;
         end

         ST_SCAN: begin
            if (op_ff == OP_FILL) begin
               mem_we    = issue_ok;
               mem_wdata = fill_ff ? '1 : '0;
            end
            if (exm_valid_ff && scan_any) begin
               // hit: zero test fails, find succeeds
               rsp_strobe_in = 1'b1;
               if (op_ff == OP_FIND) begin
                  rsp_in.flag        = 1'b1;
                  rsp_in.found_index = IDX_W'(exm_base_ff + BASE_W'(scan_pos));
               end
               state_in = ST_IDLE;
            end else if (!issue_ok && !exm_valid_ff) begin
               // range exhausted
               rsp_strobe_in = 1'b1;
               rsp_in.flag   = (op_ff == OP_ZERO);
               state_in      = ST_IDLE;
            end else begin
               // issue the next word, examine it in the next cycle
               if (issue_ok) begin
                  iss_word_in = iss_word_ff + CNT_W'(1);
                  iss_base_in = iss_base_ff + BASE_W'(WORD_BITS);
               end
               exm_valid_in = issue_ok && (op_ff != OP_FILL);
               exm_base_in  = iss_base_ff;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------
   // Store: one address, written and read in the same clocked block
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      mem_q_ff <= mem[mem_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         iss_word_ff   <= '0;
         exm_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         len_ff        <= LEN_RESET;
      end else begin
         state_ff      <= state_in;
         iss_word_ff   <= iss_word_in;
         exm_valid_ff  <= exm_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         len_ff        <= len_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      num_ff      <= num_in;
      start_ff    <= start_in;
      limit_ff    <= limit_in;
      fill_ff     <= fill_in;
      prod_ff     <= prod_in;
      iss_base_ff <= iss_base_in;
      pos_ff      <= pos_in;
      exm_base_ff <= exm_base_in;
      rsp_ff      <= rsp_in;
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // every result leaves the sequencer back in idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (state_ff == ST_IDLE))
      else $error("result strobe outside idle");

   // an accepted item either answers at once or keeps the unit busy
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_strobe_ff || busy))
      else $error("accepted item dropped");

   // examine stage only carries words while scanning
   a_exm_scan: assert property (@(posedge clock) disable iff (reset)
      exm_valid_ff |-> (state_ff == ST_SCAN))
      else $error("examine stage valid outside scan");

   // the scan never walks past the end of the store
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (iss_word_ff <= CNT_W'(NUM_WORDS)))
      else $error("scan word counter past store");

endmodule
